[sv/dpt_pkg.sv]
// Shared constants, codes and control structs for the paging translator.
`default_nettype none

package dpt_pkg;

	// Address and table geometry
	localparam int NUM_PAGES  = 256;
	localparam int NUM_FRAMES = 128;
	localparam int VA_W       = 16;
	localparam int OFFSET_W   = 8;
	localparam int PAGE_W     = $clog2(NUM_PAGES);
	localparam int FRAME_W    = $clog2(NUM_FRAMES);
	localparam int PA_W       = FRAME_W + OFFSET_W;
	localparam int SCAN_W     = $clog2(NUM_PAGES + 1);
	localparam int FCNT_W     = $clog2(NUM_FRAMES + 1);

	// Configuration port
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int REG_IDX_LSB = 2;
	localparam int REG_IDX_W   = APB_ADDR_W - REG_IDX_LSB;
	localparam logic [REG_IDX_W-1:0] REG_POLICY = 1'b0;

	// Replacement policy codes
	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic hit_commit;
		logic alloc_commit;
		logic owner_read;
		logic fifo_commit;
		logic scan_clear;
		logic scan_issue;
		logic lru_commit;
	} dpt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic page_valid;
		logic frames_full;
		logic scan_done;
		logic cmp_busy;
	} dpt_sts_t;

endpackage

`default_nettype wire

[sv/dpt_if.sv]
// Valid/ready channel interfaces for the request and response words.
`default_nettype none

interface dpt_req_if;
	logic                       valid;
	logic                       ready;
	logic [dpt_pkg::VA_W-1:0]   virtual_address;

	modport source (output valid, output virtual_address, input ready);
	modport sink   (input valid, input virtual_address, output ready);
endinterface

interface dpt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [dpt_pkg::PA_W-1:0]     physical_address;
	logic [dpt_pkg::FRAME_W-1:0]  frame_number;
	logic                         page_fault;
	logic                         evicted_valid;
	logic [dpt_pkg::PAGE_W-1:0]   evicted_page;

	modport source (output valid, output physical_address, output frame_number,
		output page_fault, output evicted_valid, output evicted_page, input ready);
	modport sink   (input valid, input physical_address, input frame_number,
		input page_fault, input evicted_valid, input evicted_page, output ready);
endinterface

`default_nettype wire

[sv/dpt_ctrl.sv]
// Controller state machine: sequences lookup, allocation, eviction and scan.
`default_nettype none

module dpt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	input  wire logic              policy,
	input  wire dpt_pkg::dpt_sts_t sts,
	output dpt_pkg::dpt_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_FIFO = 2'd2;
	localparam logic [1:0] ST_SCAN = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       commit;

	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;
	assign commit    = cmd.hit_commit || cmd.alloc_commit || cmd.fifo_commit ||
		cmd.lru_commit;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (sts.page_valid) begin
					if (out_free) begin
						cmd.hit_commit = 1'b1;
						state_d        = ST_IDLE;
					end
				end else if (!sts.frames_full) begin
					if (out_free) begin
						cmd.alloc_commit = 1'b1;
						state_d          = ST_IDLE;
					end
				end else if (policy == dpt_pkg::POLICY_FIFO) begin
					cmd.owner_read = 1'b1;
					state_d        = ST_FIFO;
				end else begin
					cmd.scan_clear = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_FIFO: begin
				if (out_free) begin
					cmd.fifo_commit = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (!sts.scan_done) begin
					cmd.scan_issue = 1'b1;
				end else if (!sts.cmp_busy && out_free) begin
					cmd.lru_commit = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[sv/dpt_dp.sv]
// Datapath: page table memories, valid bits, counters, LRU scan and result word.
`default_nettype none

module dpt_dp #(
	parameter int STAMP_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dpt_pkg::dpt_cmd_t             cmd,
	output dpt_pkg::dpt_sts_t                  sts,
	input  wire logic [dpt_pkg::VA_W-1:0]      req_va,
	output logic [dpt_pkg::PA_W-1:0]           pa,
	output logic [dpt_pkg::FRAME_W-1:0]        frame,
	output logic                               fault,
	output logic                               ev_valid,
	output logic [dpt_pkg::PAGE_W-1:0]         ev_page
);

	localparam int ENTRY_W = dpt_pkg::FRAME_W + STAMP_WIDTH;

	// Page table: frame and last-use stamp per page, read data registered
	logic [ENTRY_W-1:0]             entry_mem [dpt_pkg::NUM_PAGES];
	logic [ENTRY_W-1:0]             entry_rd_q;
	// Reverse map: page held by each frame
	logic [dpt_pkg::PAGE_W-1:0]     owner_mem [dpt_pkg::NUM_FRAMES];
	logic [dpt_pkg::PAGE_W-1:0]     owner_rd_q;

	logic [dpt_pkg::NUM_PAGES-1:0]  valid_q;
	logic [dpt_pkg::PAGE_W-1:0]     page_q;
	logic [dpt_pkg::OFFSET_W-1:0]   offset_q;
	logic [dpt_pkg::FCNT_W-1:0]     frames_used_q;
	logic [dpt_pkg::FRAME_W-1:0]    fifo_ptr_q;
	logic [STAMP_WIDTH-1:0]         access_q;

	logic [dpt_pkg::SCAN_W-1:0]     scan_idx_q;
	logic                           cmp_v_s1;
	logic [dpt_pkg::PAGE_W-1:0]     cmp_idx_s1;
	logic                           found_q;
	logic [STAMP_WIDTH-1:0]         best_stamp_q;
	logic [dpt_pkg::FRAME_W-1:0]    best_frame_q;
	logic [dpt_pkg::PAGE_W-1:0]     best_page_q;

	logic [dpt_pkg::PA_W-1:0]       pa_q;
	logic [dpt_pkg::FRAME_W-1:0]    frame_q;
	logic                           fault_q;
	logic                           ev_valid_q;
	logic [dpt_pkg::PAGE_W-1:0]     ev_page_q;

	logic [dpt_pkg::PAGE_W-1:0]     rd_addr;
	logic                           rd_en;
	logic                           commit;
	logic                           load;
	logic [dpt_pkg::FRAME_W-1:0]    commit_frame;
	logic                           commit_ev_valid;
	logic [dpt_pkg::PAGE_W-1:0]     commit_ev_page;
	logic [dpt_pkg::FRAME_W-1:0]    rd_frame;
	logic [STAMP_WIDTH-1:0]         rd_stamp;
	logic                           cand;

	assign rd_frame = entry_rd_q[ENTRY_W-1:STAMP_WIDTH];
	assign rd_stamp = entry_rd_q[STAMP_WIDTH-1:0];
	assign rd_en    = cmd.accept || cmd.scan_issue;
	assign rd_addr  = cmd.accept ? req_va[dpt_pkg::VA_W-1 -: dpt_pkg::PAGE_W]
		: scan_idx_q[dpt_pkg::PAGE_W-1:0];
	assign load     = cmd.alloc_commit || cmd.fifo_commit || cmd.lru_commit;
	assign commit   = cmd.hit_commit || load;
	assign cand     = valid_q[cmp_idx_s1] && (!found_q || rd_stamp < best_stamp_q);

	assign sts.page_valid  = valid_q[page_q];
	assign sts.frames_full = frames_used_q == dpt_pkg::FCNT_W'(dpt_pkg::NUM_FRAMES);
	assign sts.scan_done   = scan_idx_q == dpt_pkg::SCAN_W'(dpt_pkg::NUM_PAGES);
	assign sts.cmp_busy    = cmp_v_s1;

	always_comb begin
		commit_frame    = rd_frame;
		commit_ev_valid = 1'b0;
		commit_ev_page  = '0;
		if (cmd.alloc_commit) begin
			commit_frame = frames_used_q[dpt_pkg::FRAME_W-1:0];
		end else if (cmd.fifo_commit) begin
			commit_frame    = fifo_ptr_q;
			commit_ev_valid = 1'b1;
			commit_ev_page  = owner_rd_q;
		end else if (cmd.lru_commit) begin
			commit_frame    = found_q ? best_frame_q : '0;
			commit_ev_valid = found_q;
			commit_ev_page  = found_q ? best_page_q : '0;
		end
	end

	// Memories
	always_ff @(posedge clk) begin
		if (rd_en) begin
			entry_rd_q <= entry_mem[rd_addr];
		end
		if (commit) begin
			entry_mem[page_q] <= {commit_frame, access_q};
		end
		if (cmd.owner_read) begin
			owner_rd_q <= owner_mem[fifo_ptr_q];
		end
		if (load) begin
			owner_mem[commit_frame] <= page_q;
		end
	end

	// Request word, scan best candidate and result word
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			page_q   <= req_va[dpt_pkg::VA_W-1 -: dpt_pkg::PAGE_W];
			offset_q <= req_va[dpt_pkg::OFFSET_W-1:0];
		end
		cmp_idx_s1 <= scan_idx_q[dpt_pkg::PAGE_W-1:0];
		if (cmp_v_s1 && cand) begin
			best_stamp_q <= rd_stamp;
			best_frame_q <= rd_frame;
			best_page_q  <= cmp_idx_s1;
		end
		if (commit) begin
			pa_q       <= {commit_frame, offset_q};
			frame_q    <= commit_frame;
			fault_q    <= load;
			ev_valid_q <= commit_ev_valid;
			ev_page_q  <= commit_ev_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			frames_used_q <= '0;
			fifo_ptr_q    <= '0;
			access_q      <= '0;
			scan_idx_q    <= '0;
			cmp_v_s1      <= 1'b0;
			found_q       <= 1'b0;
		end else begin
			if (commit && commit_ev_valid) begin
				valid_q[commit_ev_page] <= 1'b0;
			end
			if (load) begin
				valid_q[page_q] <= 1'b1;
			end
			if (cmd.alloc_commit) begin
				frames_used_q <= frames_used_q + 1'b1;
			end
			if (cmd.fifo_commit) begin
				if (fifo_ptr_q == dpt_pkg::FRAME_W'(dpt_pkg::NUM_FRAMES - 1)) begin
					fifo_ptr_q <= '0;
				end else begin
					fifo_ptr_q <= fifo_ptr_q + 1'b1;
				end
			end
			// Saturate the use counter
			if (commit && access_q != '1) begin
				access_q <= access_q + 1'b1;
			end
			if (cmd.scan_clear) begin
				scan_idx_q <= '0;
				cmp_v_s1   <= 1'b0;
				found_q    <= 1'b0;
			end else begin
				cmp_v_s1 <= cmd.scan_issue;
				if (cmd.scan_issue) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (cmp_v_s1 && cand) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	assign pa       = pa_q;
	assign frame    = frame_q;
	assign fault    = fault_q;
	assign ev_valid = ev_valid_q;
	assign ev_page  = ev_page_q;

endmodule

`default_nettype wire

[sv/demand_paging_translator.sv]
// Demand-paging address translator top level: channels, policy register, core.
//
// Usage: a 16-bit virtual address word enters on req (page in bits 15..8,
// offset in bits 7..0); one result word leaves on rsp for each request:
// physical address, frame, fault flag and any evicted page. Both channels
// move a word when valid and ready are high at a rising clock edge.
// The APB port holds one register at byte address 0, the replacement policy
// (0 FIFO, 1 least recently used); write it only while no word is in flight.
// A hit, or a fault that takes a free frame, commits straight from lookup;
// a FIFO eviction first reads the reverse map, and an LRU eviction walks the
// stamp memory one page per cycle through its single read port. A new request
// is taken the cycle after the result is registered, so a request is never
// accepted before the previous one has committed. Reset clears the
// valid bits, frame count, FIFO pointer,
// use counter and policy; no clearing pass is needed. A stalled receiver
// holds the result word; the next request can still be taken, and its own
// result waits in the controller until the output register drains.
`default_nettype none

module demand_paging_translator #(
	parameter int STAMP_WIDTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	dpt_req_if.sink                                   req,
	dpt_rsp_if.source                                 rsp,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [dpt_pkg::APB_ADDR_W-1:0]       paddr,
	input  wire logic [dpt_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [dpt_pkg::APB_DATA_W-1:0]            prdata,
	output logic                                      pready
);

	logic                 policy_q;
	logic                 cfg_wr;
	logic                 req_ready;
	logic                 rsp_valid;
	dpt_pkg::dpt_cmd_t    cmd;
	dpt_pkg::dpt_sts_t    sts;

	// Policy register: written in the APB access phase, read back zero-extended
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		paddr[dpt_pkg::APB_ADDR_W-1:dpt_pkg::REG_IDX_LSB] == dpt_pkg::REG_POLICY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= dpt_pkg::POLICY_FIFO;
		end else if (cfg_wr) begin
			policy_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[dpt_pkg::APB_ADDR_W-1:dpt_pkg::REG_IDX_LSB] == dpt_pkg::REG_POLICY) begin
			prdata = {{(dpt_pkg::APB_DATA_W-1){1'b0}}, policy_q};
		end
	end

	// Controller: sequences each request through lookup and replacement
	dpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.policy    (policy_q),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: page table, reverse map, counters and the result register
	dpt_dp #(
		.STAMP_WIDTH (STAMP_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req_va   (req.virtual_address),
		.pa       (rsp.physical_address),
		.frame    (rsp.frame_number),
		.fault    (rsp.page_fault),
		.ev_valid (rsp.evicted_valid),
		.ev_page  (rsp.evicted_page)
	);

	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;

endmodule

`default_nettype wire

[verif/tb_demand_paging_translator.sv]
// Self-checking testbench for the demand-paging translator: FIFO and LRU replacement.
module tb_demand_paging_translator;
	import dpt_pkg::*;

	localparam int STAMP_W = 32;
	localparam int MAX_GAP = 5;
	// Allow an LRU eviction walk plus margin after the last word has come back.
	localparam int DRAIN_CYCLES = NUM_PAGES + 16;
	localparam logic [APB_ADDR_W-1:0] POLICY_ADDR = {REG_POLICY, {REG_IDX_LSB{1'b0}}};

	// Corners of the address space: lowest and highest page, lowest and highest
	// offset, alternating bit patterns, and hits on pages loaded just before.
	localparam logic [VA_W-1:0] EDGE_ADDRESSES [10] = '{
		16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h8001,
		16'h7FFE, 16'h5555, 16'hAAAA, 16'h0080, 16'hFF7F
	};

	// One result word as it leaves the rsp channel.
	typedef struct packed {
		logic [PA_W-1:0]    physical_address;
		logic [FRAME_W-1:0] frame_number;
		logic               page_fault;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
	} xlat_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	dpt_req_if req_ch();
	dpt_rsp_if rsp_ch();

	demand_paging_translator #(
		.STAMP_WIDTH(STAMP_W)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// Our own copy of the page table and the allocation state.
	logic               resident       [NUM_PAGES];
	logic [FRAME_W-1:0] resident_frame [NUM_PAGES];
	logic [STAMP_W-1:0] last_use       [NUM_PAGES];
	int unsigned        frames_taken;
	logic [FRAME_W-1:0] fifo_victim_frame;
	logic [STAMP_W-1:0] use_count;
	logic               policy;

	// Translations predicted for accepted requests, oldest first.
	xlat_word_t expected_words[$];
	int         mismatch_count;
	int         sent_count;
	int         req_gap_max   = MAX_GAP;
	int         rsp_stall_max = MAX_GAP;
	logic [PAGE_W-1:0] hot_base;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Translate one address against the table copy and update it the way the
	// block does: refresh the stamp on a hit, hand out free frames in order,
	// then evict by FIFO pointer or by smallest stamp (lowest page on a tie).
	function automatic xlat_word_t translate_address(input logic [VA_W-1:0] va);
		logic [PAGE_W-1:0]   page;
		logic [OFFSET_W-1:0] offset;
		logic [STAMP_W-1:0]  now;
		logic [STAMP_W-1:0]  oldest;
		logic [FRAME_W-1:0]  frame;
		logic [PAGE_W-1:0]   victim;
		logic                found;
		xlat_word_t          w;
		page   = PAGE_W'(int'(va >> OFFSET_W) % NUM_PAGES);
		offset = va[OFFSET_W-1:0];
		now    = use_count;
		w      = '0;
		found  = 1'b0;
		oldest = '0;
		victim = '0;
		if (resident[page]) begin
			last_use[page] = now;
			frame = resident_frame[page];
		end else begin
			w.page_fault = 1'b1;
			if (frames_taken < NUM_FRAMES) begin
				frame = FRAME_W'(frames_taken);
				frames_taken++;
			end else if (policy == POLICY_FIFO) begin
				frame = fifo_victim_frame;
				for (int j = 0; j < NUM_PAGES && !found; j++) begin
					if (resident[j] && resident_frame[j] == frame) begin
						resident[j]     = 1'b0;
						found           = 1'b1;
						w.evicted_valid = 1'b1;
						w.evicted_page  = PAGE_W'(j);
					end
				end
				fifo_victim_frame = FRAME_W'((int'(fifo_victim_frame) + 1) % NUM_FRAMES);
			end else begin
				for (int j = 0; j < NUM_PAGES; j++) begin
					if (resident[j] && (!found || last_use[j] < oldest)) begin
						found  = 1'b1;
						oldest = last_use[j];
						victim = PAGE_W'(j);
					end
				end
				// No resident page at all cannot occur with full frames; fall back to frame 0.
				frame = '0;
				if (found) begin
					frame            = resident_frame[victim];
					resident[victim] = 1'b0;
					w.evicted_valid  = 1'b1;
					w.evicted_page   = victim;
				end
			end
			resident[page]       = 1'b1;
			resident_frame[page] = frame;
			last_use[page]       = now;
		end
		// Saturate the use counter so late stamps tie rather than wrap.
		if (use_count != '1)
			use_count++;
		w.physical_address = {frame, offset};
		w.frame_number     = frame;
		return w;
	endfunction

	// Draw an address; in hot mode most pages fall in a window of 96 pages, which
	// fits in the frames, so LRU has a working set to protect.
	function automatic logic [VA_W-1:0] pick_address(input bit hot);
		logic [PAGE_W-1:0] page;
		if (hot && $urandom_range(0, 99) < 70)
			page = hot_base + PAGE_W'($urandom_range(0, 95));
		else
			page = PAGE_W'($urandom);
		return {page, OFFSET_W'($urandom)};
	endfunction

	// Offer one request word after a random gap and predict its result once taken.
	// Keep valid high across back-to-back words; drop it only for a gap.
	task automatic send_address(input logic [VA_W-1:0] va);
		int gap;
		// Switch between idle and busy stretches every 64 words on both sides.
		if (sent_count % 64 == 0) begin
			req_gap_max   = $urandom_range(0, 1) * MAX_GAP;
			rsp_stall_max = $urandom_range(0, 1) * MAX_GAP;
		end
		gap = $urandom_range(0, req_gap_max);
		if (gap > 0) begin
			req_ch.valid           <= 1'b0;
			req_ch.virtual_address <= VA_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		req_ch.valid           <= 1'b1;
		req_ch.virtual_address <= va;
		do @(posedge clk); while (!req_ch.ready);
		expected_words.push_back(translate_address(va));
		sent_count++;
	endtask

	// Hold off new requests until every predicted word has come back.
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_words.size() != 0);
	endtask

	// Write the policy register, then read it back in the same APB transfer run.
	task automatic set_policy(input logic value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= POLICY_ADDR;
		pwdata  <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		policy = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(policy)) begin
			$display("%0t policy readback: expected %0h actual %0h", $time, policy, prdata);
			mismatch_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic void check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s: expected %0h actual %0h", $time, field, want, got);
			mismatch_count++;
		end
	endfunction

	// Directed corners under FIFO right after reset: faults on free frames and hits.
	task automatic test_edge_addresses();
		set_policy(POLICY_FIFO);
		foreach (EDGE_ADDRESSES[i])
			send_address(EDGE_ADDRESSES[i]);
		wait_for_results();
	endtask

	// LRU selected while free frames remain: loads must still take frames in order.
	task automatic test_lru_free_frames();
		set_policy(POLICY_LRU);
		repeat (40)
			send_address({PAGE_W'($urandom_range(0, 63)), OFFSET_W'($urandom)});
		wait_for_results();
	endtask

	// Fill all frames and run well past a full turn of the FIFO pointer.
	// Pause halfway until the pipe is empty, then carry on.
	task automatic test_fifo_replacement();
		set_policy(POLICY_FIFO);
		for (int i = 0; i < 600; i++) begin
			if (i == 300)
				wait_for_results();
			send_address(pick_address(1'b0));
		end
		wait_for_results();
	endtask

	// LRU eviction on full frames with a drifting working set; stamps carry over
	// from the FIFO phase.
	task automatic test_lru_replacement();
		set_policy(POLICY_LRU);
		for (int i = 0; i < 500; i++) begin
			if (i % 100 == 0)
				hot_base = PAGE_W'($urandom);
			send_address(pick_address(1'b1));
		end
		wait_for_results();
	endtask

	// Back to FIFO: the pointer resumes where it stopped, not at frame 0.
	task automatic test_fifo_after_lru();
		set_policy(POLICY_FIFO);
		repeat (400)
			send_address(pick_address(1'b0));
		wait_for_results();
	endtask

	// LRU again after FIFO evictions reshuffled the frames.
	task automatic test_lru_after_fifo();
		set_policy(POLICY_LRU);
		for (int i = 0; i < 400; i++) begin
			if (i % 80 == 0)
				hot_base = PAGE_W'($urandom);
			send_address(pick_address(1'b1));
		end
		wait_for_results();
	endtask

	// Stimulus and end of run.
	initial begin
		arst_n = 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		req_ch.valid           <= 1'b0;
		req_ch.virtual_address <= '0;
		mismatch_count    = 0;
		sent_count        = 0;
		hot_base          = '0;
		frames_taken      = 0;
		fifo_victim_frame = '0;
		use_count         = '0;
		policy            = POLICY_FIFO;
		for (int i = 0; i < NUM_PAGES; i++) begin
			resident[i]       = 1'b0;
			resident_frame[i] = '0;
			last_use[i]       = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_edge_addresses();
		test_lru_free_frames();
		test_fifo_replacement();
		test_lru_replacement();
		test_fifo_after_lru();
		test_lru_after_fifo();
		// Watch for stray words a while after the last expected one.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("demand_paging_translator: match");
		else
			$display("demand_paging_translator: mismatch");
		$finish;
	end

	// Result side: stall a random number of cycles, then take the next word and
	// compare it field by field with the oldest prediction.
	initial begin
		xlat_word_t want;
		int         stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(0, rsp_stall_max);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			if (expected_words.size() == 0) begin
				$display("%0t result word with none pending: expected none actual pa %0h",
					$time, rsp_ch.physical_address);
				mismatch_count++;
			end else begin
				want = expected_words.pop_front();
				check_field("physical_address", 32'(want.physical_address),
					32'(rsp_ch.physical_address));
				check_field("frame_number", 32'(want.frame_number), 32'(rsp_ch.frame_number));
				check_field("page_fault", 32'(want.page_fault), 32'(rsp_ch.page_fault));
				check_field("evicted_valid", 32'(want.evicted_valid),
					32'(rsp_ch.evicted_valid));
				check_field("evicted_page", 32'(want.evicted_page), 32'(rsp_ch.evicted_page));
			end
		end
	end

	// Hang guard, several times the slowest legal run.
	initial begin
		#40_000_000;
		$display("demand_paging_translator: mismatch");
		$finish;
	end

endmodule
